// ----- design/tbc_pkg.sv -----
`default_nettype none

package tbc_pkg;

   localparam int CAPACITY = 256;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 9;
   localparam int BYTE_W   = 8;
   localparam int CMD_W    = 3;
   localparam int STAT_W   = 2;

   // command codes; code 7 is unused and reports the state unchanged
   typedef enum logic [CMD_W-1:0] {
      CMD_FWD    = 3'd0,
      CMD_BACK   = 3'd1,
      CMD_START  = 3'd2,
      CMD_END    = 3'd3,
      CMD_INSERT = 3'd4,
      CMD_DELETE = 3'd5,
      CMD_READ   = 3'd6
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_MOVE_RD,
      S_MOVE_WR,
      S_PUT_CH,
      S_READ_WAIT,
      S_FINISH
   } state_type;

   typedef enum logic [1:0] {
      RD_WALK_DN,
      RD_WALK_UP,
      RD_INDEX
   } rd_sel_type;

   typedef enum logic {
      WR_SHIFT,
      WR_CHAR
   } wr_sel_type;

   typedef enum logic [2:0] {
      WALK_HOLD,
      WALK_FROM_LEN,
      WALK_FROM_CUR,
      WALK_INC,
      WALK_DEC
   } walk_op_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_INC,
      CUR_DEC,
      CUR_ZERO,
      CUR_END
   } cur_op_type;

   typedef enum logic [1:0] {
      LEN_HOLD,
      LEN_INC,
      LEN_DEC
   } len_op_type;

   // controller -> datapath
   typedef struct packed {
      logic        latch_req;
      cur_op_type  cur_op;
      len_op_type  len_op;
      walk_op_type walk_op;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        wr_en;
      wr_sel_type  wr_sel;
      logic        set_stat;
      status_type  stat_code;
      logic        capture_read;
      logic        load_rsp;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      cmd_type cmd;
      logic    full;
      logic    cur_lt_len;
      logic    cur_p1_lt_len;
      logic    cur_nonzero;
      logic    idx_lt_len;
      logic    walk_gt_cur1;
      logic    walk_p2_lt_len;
      logic    rsp_free;
   } dp_stat_type;

endpackage

`default_nettype wire

// ----- design/tbc_ram.sv -----
`default_nettype none

module tbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/tbc_ctrl.sv -----
`default_nettype none

module tbc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire tbc_pkg::dp_stat_type stat,
   output tbc_pkg::dp_cmd_type       cmd
);

   tbc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tbc_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tbc_pkg::S_IDLE: begin
            if (req_tvalid) state_in = tbc_pkg::S_DECODE;
         end
         tbc_pkg::S_DECODE: begin
            case (stat.cmd)
               tbc_pkg::CMD_INSERT: begin
                  if (stat.full)            state_in = tbc_pkg::S_FINISH;
                  else if (stat.cur_lt_len) state_in = tbc_pkg::S_MOVE_RD;
                  else                      state_in = tbc_pkg::S_PUT_CH;
               end
               tbc_pkg::CMD_DELETE: begin
                  if (stat.cur_p1_lt_len) state_in = tbc_pkg::S_MOVE_RD;
                  else                    state_in = tbc_pkg::S_FINISH;
               end
               tbc_pkg::CMD_READ: begin
                  if (stat.idx_lt_len) state_in = tbc_pkg::S_READ_WAIT;
                  else                 state_in = tbc_pkg::S_FINISH;
               end
               default: state_in = tbc_pkg::S_FINISH;
            endcase
         end
         tbc_pkg::S_MOVE_RD: state_in = tbc_pkg::S_MOVE_WR;
         tbc_pkg::S_MOVE_WR: begin
            if (stat.cmd == tbc_pkg::CMD_INSERT) begin
               state_in = stat.walk_gt_cur1 ? tbc_pkg::S_MOVE_RD : tbc_pkg::S_PUT_CH;
            end else begin
               state_in = stat.walk_p2_lt_len ? tbc_pkg::S_MOVE_RD : tbc_pkg::S_FINISH;
            end
         end
         tbc_pkg::S_PUT_CH:    state_in = tbc_pkg::S_FINISH;
         tbc_pkg::S_READ_WAIT: state_in = tbc_pkg::S_FINISH;
         tbc_pkg::S_FINISH: begin
            if (stat.rsp_free) state_in = tbc_pkg::S_IDLE;
         end
         default: state_in = tbc_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd              = '0;
      cmd.cur_op       = tbc_pkg::CUR_HOLD;
      cmd.len_op       = tbc_pkg::LEN_HOLD;
      cmd.walk_op      = tbc_pkg::WALK_HOLD;
      cmd.rd_sel       = tbc_pkg::RD_INDEX;
      cmd.wr_sel       = tbc_pkg::WR_SHIFT;
      cmd.stat_code    = tbc_pkg::ST_OK;
      req_tready       = 1'b0;
      case (state_ff)
         tbc_pkg::S_IDLE: begin
            req_tready    = !reset;
            cmd.latch_req = req_tvalid;
         end
         tbc_pkg::S_DECODE: begin
            case (stat.cmd)
               tbc_pkg::CMD_FWD: begin
                  if (stat.cur_lt_len) cmd.cur_op = tbc_pkg::CUR_INC;
               end
               tbc_pkg::CMD_BACK: begin
                  if (stat.cur_nonzero) cmd.cur_op = tbc_pkg::CUR_DEC;
               end
               tbc_pkg::CMD_START: cmd.cur_op = tbc_pkg::CUR_ZERO;
               tbc_pkg::CMD_END:   cmd.cur_op = tbc_pkg::CUR_END;
               tbc_pkg::CMD_INSERT: begin
                  if (stat.full) begin
                     cmd.set_stat  = 1'b1;
                     cmd.stat_code = tbc_pkg::ST_FULL;
                  end else begin
                     cmd.walk_op = tbc_pkg::WALK_FROM_LEN;
                  end
               end
               tbc_pkg::CMD_DELETE: begin
                  cmd.walk_op = tbc_pkg::WALK_FROM_CUR;
                  // single trailing byte: nothing to shift
                  if (stat.cur_lt_len && !stat.cur_p1_lt_len) cmd.len_op = tbc_pkg::LEN_DEC;
               end
               tbc_pkg::CMD_READ: begin
                  if (stat.idx_lt_len) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = tbc_pkg::RD_INDEX;
                  end else begin
                     cmd.set_stat  = 1'b1;
                     cmd.stat_code = tbc_pkg::ST_RANGE;
                  end
               end
               default: ;
            endcase
         end
         tbc_pkg::S_MOVE_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = (stat.cmd == tbc_pkg::CMD_INSERT) ? tbc_pkg::RD_WALK_DN
                                                           : tbc_pkg::RD_WALK_UP;
         end
         tbc_pkg::S_MOVE_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = tbc_pkg::WR_SHIFT;
            if (stat.cmd == tbc_pkg::CMD_INSERT) begin
               cmd.walk_op = tbc_pkg::WALK_DEC;
            end else begin
               cmd.walk_op = tbc_pkg::WALK_INC;
               if (!stat.walk_p2_lt_len) cmd.len_op = tbc_pkg::LEN_DEC;
            end
         end
         tbc_pkg::S_PUT_CH: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = tbc_pkg::WR_CHAR;
            cmd.cur_op = tbc_pkg::CUR_INC;
            cmd.len_op = tbc_pkg::LEN_INC;
         end
         tbc_pkg::S_READ_WAIT: cmd.capture_read = 1'b1;
         tbc_pkg::S_FINISH:    cmd.load_rsp     = stat.rsp_free;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// ----- design/tbc_dp.sv -----
`default_nettype none

module tbc_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [2:0]           req_tuser,
   input  wire logic [15:0]          req_tdata,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [31:0]               rsp_tdata,
   output logic [1:0]                rsp_tuser,
   input  wire tbc_pkg::dp_cmd_type  cmd,
   output tbc_pkg::dp_stat_type      stat
);

   localparam int AW = tbc_pkg::ADDR_W;
   localparam int CW = tbc_pkg::CNT_W;

   tbc_pkg::cmd_type             op_ff;
   logic [tbc_pkg::BYTE_W-1:0]   ch_ff;
   logic [tbc_pkg::BYTE_W-1:0]   index_ff;
   logic [CW-1:0]                cursor_ff, cursor_in;
   logic [CW-1:0]                length_ff, length_in;
   logic [CW-1:0]                walk_ff, walk_in;
   logic [tbc_pkg::BYTE_W-1:0]   rbyte_ff;
   tbc_pkg::status_type          stat_ff;

   logic                         rsp_valid_ff;
   logic [tbc_pkg::POS_W-1:0]    rsp_cur_ff;
   logic [tbc_pkg::POS_W-1:0]    rsp_len_ff;
   logic [tbc_pkg::BYTE_W-1:0]   rsp_byte_ff;
   tbc_pkg::status_type          rsp_stat_ff;

   logic                         ram_wr_en;
   logic [AW-1:0]                ram_wr_addr;
   logic [tbc_pkg::BYTE_W-1:0]   ram_wr_data;
   logic [AW-1:0]                ram_rd_addr;
   logic [tbc_pkg::BYTE_W-1:0]   ram_rd_data;
   logic [CW-1:0]                walk_dn;
   logic [CW-1:0]                walk_up;
   logic [CW:0]                  cur_p1;
   logic [CW:0]                  walk_p2;

   assign walk_dn = walk_ff - CW'(1);
   assign walk_up = walk_ff + CW'(1);
   assign cur_p1  = {1'b0, cursor_ff} + (CW+1)'(1);
   assign walk_p2 = {1'b0, walk_ff} + (CW+1)'(2);

   // request payload
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff    <= tbc_pkg::cmd_type'(req_tuser);
         ch_ff    <= req_tdata[7:0];
         index_ff <= req_tdata[15:8];
      end
   end

   // cursor, length and shift pointer
   always_comb begin
      case (cmd.cur_op)
         tbc_pkg::CUR_INC:  cursor_in = cursor_ff + CW'(1);
         tbc_pkg::CUR_DEC:  cursor_in = cursor_ff - CW'(1);
         tbc_pkg::CUR_ZERO: cursor_in = '0;
         tbc_pkg::CUR_END:  cursor_in = length_ff;
         default:           cursor_in = cursor_ff;
      endcase
      case (cmd.len_op)
         tbc_pkg::LEN_INC: length_in = length_ff + CW'(1);
         tbc_pkg::LEN_DEC: length_in = length_ff - CW'(1);
         default:          length_in = length_ff;
      endcase
      case (cmd.walk_op)
         tbc_pkg::WALK_FROM_LEN: walk_in = length_ff;
         tbc_pkg::WALK_FROM_CUR: walk_in = cursor_ff;
         tbc_pkg::WALK_INC:      walk_in = walk_up;
         tbc_pkg::WALK_DEC:      walk_in = walk_dn;
         default:                walk_in = walk_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         length_ff <= '0;
      end else begin
         cursor_ff <= cursor_in;
         length_ff <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff <= walk_in;
   end

   // per-item read byte and status
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         rbyte_ff <= '0;
         stat_ff  <= tbc_pkg::ST_OK;
      end else begin
         if (cmd.capture_read) rbyte_ff <= ram_rd_data;
         if (cmd.set_stat)     stat_ff  <= cmd.stat_code;
      end
   end

   // text store
   always_comb begin
      case (cmd.rd_sel)
         tbc_pkg::RD_WALK_DN: ram_rd_addr = walk_dn[AW-1:0];
         tbc_pkg::RD_WALK_UP: ram_rd_addr = walk_up[AW-1:0];
         default:             ram_rd_addr = index_ff;
      endcase
      if (cmd.wr_sel == tbc_pkg::WR_CHAR) begin
         ram_wr_addr = cursor_ff[AW-1:0];
         ram_wr_data = ch_ff;
      end else begin
         ram_wr_addr = walk_ff[AW-1:0];
         ram_wr_data = ram_rd_data;
      end
      ram_wr_en = cmd.wr_en;
   end

   tbc_ram #(
      .WIDTH (tbc_pkg::BYTE_W),
      .DEPTH (tbc_pkg::CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_cur_ff  <= tbc_pkg::POS_W'(cursor_ff);
         rsp_len_ff  <= tbc_pkg::POS_W'(length_ff);
         rsp_byte_ff <= rbyte_ff;
         rsp_stat_ff <= stat_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_byte_ff, rsp_len_ff, rsp_cur_ff};
   assign rsp_tuser  = rsp_stat_ff;

   // status to controller
   always_comb begin
      stat.cmd            = op_ff;
      stat.full           = (length_ff >= CW'(tbc_pkg::CAPACITY));
      stat.cur_lt_len     = (cursor_ff < length_ff);
      stat.cur_p1_lt_len  = (cur_p1 < {1'b0, length_ff});
      stat.cur_nonzero    = (cursor_ff != '0);
      stat.idx_lt_len     = (CW'(index_ff) < length_ff);
      stat.walk_gt_cur1   = ({1'b0, walk_ff} > cur_p1);
      stat.walk_p2_lt_len = (walk_p2 < {1'b0, length_ff});
      stat.rsp_free       = !rsp_valid_ff || rsp_tready;
   end

endmodule

`default_nettype wire

// ----- design/text_buffer_with_cursor.sv -----
`default_nettype none

// Channel  Dir  Handshake              Payload
// req_     in   req_tvalid/req_tready  tuser: cmd[2:0]
//                                      tdata: ch[7:0], index[15:8]
// rsp_     out  rsp_tvalid/rsp_tready  tdata: cursor_pos[8:0], text_length[17:9],
//                                             read_byte[25:18], zeros[31:26]
//                                      tuser: status[1:0]
//
// One item at a time. After the accept, each item passes decode and ends in the
// finish state, which loads the result register. A read waits in a read-wait
// state; an insert below capacity shifts when the cursor is below the length,
// then puts its byte; a delete shifts when a byte follows the one at the cursor.
// Each shifted byte takes a read and a write state on the single-port-pair text
// RAM. req_tready rises the cycle after the result is loaded. Synchronous reset
// clears cursor, length and the output valid; the text RAM is not cleared (only
// bytes below the length are read). A stalled result holds finish until rsp_tready.

module text_buffer_with_cursor (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [2:0]  req_tuser,   // cmd[2:0]
   input  wire logic [15:0] req_tdata,   // ch[7:0], index[15:8]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // cursor_pos[8:0], text_length[17:9], read_byte[25:18]
   output logic [1:0]       rsp_tuser    // status[1:0]
);

   tbc_pkg::dp_cmd_type  dp_cmd;
   tbc_pkg::dp_stat_type dp_stat;

   // sequencer: decode, shift loop, result handoff
   tbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (dp_stat),
      .cmd        (dp_cmd)
   );

   // counters, text RAM and output register
   tbc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (dp_cmd),
      .stat       (dp_stat)
   );

endmodule

`default_nettype wire

// ----- design/tbc_chk.sv -----
`default_nettype none

module tbc_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // one item in flight: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("accepted a second item while busy");

   // cursor never passes the end and the length fits the capacity
   a_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[8:0] <= rsp_tdata[17:9]) &&
                     (rsp_tdata[17:9] <= 9'(tbc_pkg::CAPACITY)))
      else $error("cursor or length out of range");

   // refused insert only when full
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == tbc_pkg::ST_FULL |->
         rsp_tdata[17:9] == 9'(tbc_pkg::CAPACITY))
      else $error("insert refused below capacity");

   // read byte is zero unless status is ok
   a_rbyte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != tbc_pkg::ST_OK |-> rsp_tdata[25:18] == 8'd0)
      else $error("nonzero read byte on flagged result");

endmodule

bind text_buffer_with_cursor tbc_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
